// ----- rtl/stl_pkg.sv -----
// Package: token kinds, error codes, scan modes and shared types for the lexer.
`timescale 1ns / 1ps
package stl_pkg;

    localparam int unsigned MAX_TEXT_LEN_DEF  = 255;
    localparam int unsigned KEYWORD_CHARS_DEF = 9;
    localparam int unsigned QUEUE_DEPTH       = 2;

    localparam logic [5:0] K_PLUS          = 6'd0;
    localparam logic [5:0] K_INCREMENT     = 6'd1;
    localparam logic [5:0] K_MINUS         = 6'd2;
    localparam logic [5:0] K_DECREMENT     = 6'd3;
    localparam logic [5:0] K_INVERSE       = 6'd4;
    localparam logic [5:0] K_NOT_EQ        = 6'd5;
    localparam logic [5:0] K_NOT_EQ_STRICT = 6'd6;
    localparam logic [5:0] K_DIV           = 6'd7;
    localparam logic [5:0] K_LINE_COMMENT  = 6'd8;
    localparam logic [5:0] K_BLOCK_COMMENT = 6'd9;
    localparam logic [5:0] K_STAR          = 6'd10;
    localparam logic [5:0] K_COMMA         = 6'd11;
    localparam logic [5:0] K_LPAREN        = 6'd12;
    localparam logic [5:0] K_RPAREN        = 6'd13;
    localparam logic [5:0] K_SEMI          = 6'd14;
    localparam logic [5:0] K_LBRACE        = 6'd15;
    localparam logic [5:0] K_COLON         = 6'd16;
    localparam logic [5:0] K_LSQ           = 6'd17;
    localparam logic [5:0] K_RSQ           = 6'd18;
    localparam logic [5:0] K_RBRACE        = 6'd19;
    localparam logic [5:0] K_DOT           = 6'd20;
    localparam logic [5:0] K_ASSIGN        = 6'd21;
    localparam logic [5:0] K_EQ            = 6'd22;
    localparam logic [5:0] K_EQ_STRICT     = 6'd23;
    localparam logic [5:0] K_LT            = 6'd24;
    localparam logic [5:0] K_GT            = 6'd25;
    localparam logic [5:0] K_LE            = 6'd26;
    localparam logic [5:0] K_GE            = 6'd27;
    localparam logic [5:0] K_AND           = 6'd28;
    localparam logic [5:0] K_OR            = 6'd29;
    localparam logic [5:0] K_STRING        = 6'd30;
    localparam logic [5:0] K_NUMBER        = 6'd31;
    localparam logic [5:0] K_WORD          = 6'd32;
    localparam logic [5:0] K_IF            = 6'd33;
    localparam logic [5:0] K_FOR           = 6'd34;
    localparam logic [5:0] K_WHILE         = 6'd35;
    localparam logic [5:0] K_ELSE          = 6'd36;
    localparam logic [5:0] K_NAN           = 6'd37;
    localparam logic [5:0] K_FUNCTION      = 6'd38;
    localparam logic [5:0] K_UNDEFINED     = 6'd39;
    localparam logic [5:0] K_NULL          = 6'd40;
    localparam logic [5:0] K_THIS          = 6'd41;
    localparam logic [5:0] K_NEW           = 6'd42;
    localparam logic [5:0] K_RETURN        = 6'd43;
    localparam logic [5:0] K_TYPEOF        = 6'd44;
    localparam logic [5:0] K_BOOLEAN       = 6'd45;

    localparam logic [1:0] E_NONE      = 2'd0;
    localparam logic [1:0] E_UNTERM    = 2'd1;
    localparam logic [1:0] E_NO_PAREN  = 2'd2;
    localparam logic [1:0] E_TWO_POINT = 2'd3;

    typedef enum logic [4:0] {
        M_IDLE, M_PLUS, M_MINUS, M_BANG, M_BANG_EQ, M_SLASH, M_LINE, M_BLOCK,
        M_BLOCK_STAR, M_EQ, M_LT, M_GT, M_AMP, M_BAR, M_STR, M_NUM, M_WORD,
        M_WAIT_IF, M_WAIT_FOR, M_WAIT_WHILE
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  len;
        logic [31:0] start;
        logic [1:0]  err;
    } t_token;

    // Tokens completed by one source byte: one or two.
    typedef struct packed {
        logic       two;
        t_token     tok1;
        t_token     tok0;
    } t_bundle;

    typedef struct packed {
        logic    push;
        t_bundle data;
    } t_push;

endpackage

// ----- rtl/stl_if.sv -----
// Interfaces: byte input channel and token output channel.
`timescale 1ns / 1ps
interface stl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;
    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface stl_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [7:0]  text_length;
    logic [31:0] start_offset;
    logic [1:0]  error_code;
    logic        last_of_run;
    modport source (output valid, output token_kind, output text_length,
                    output start_offset, output error_code, output last_of_run,
                    input ready);
    modport sink (input valid, input token_kind, input text_length,
                  input start_offset, input error_code, input last_of_run,
                  output ready);
endinterface

// ----- rtl/stl_front.sv -----
// Front end: scanner FSM, one byte per cycle when accepted, builds token bundles.
`timescale 1ns / 1ps
module stl_front #(
    parameter int unsigned MAX_TEXT_LEN  = stl_pkg::MAX_TEXT_LEN_DEF,
    parameter int unsigned KEYWORD_CHARS = stl_pkg::KEYWORD_CHARS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_char,
    input  logic           i_end,
    output stl_pkg::t_push o_push
);
    import stl_pkg::*;

    localparam int unsigned LEN_CAP = (MAX_TEXT_LEN < 255) ? MAX_TEXT_LEN : 255;
    localparam int unsigned KW_W    = $clog2(KEYWORD_CHARS);

    t_mode       r_mode, n_mode;
    logic [7:0]  r_len, n_len;
    logic [31:0] r_start, n_start;
    logic [31:0] r_pos, n_pos;
    logic [7:0]  r_quote, n_quote;
    logic        r_point, n_point;
    logic [2:0]  r_eq, n_eq;
    logic [7:0]  r_buf [KEYWORD_CHARS];

    logic            buf_we;
    logic [KW_W-1:0] buf_idx;
    t_token          tok [2];
    logic [1:0]      ntok;
    logic            redo;
    logic [5:0]      kw;
    logic [7:0]      len_up;
    logic            c_digit, c_alpha, c_wordch;
    logic [7:0]      c;

    assign c       = i_char;
    assign c_digit = (c >= "0") && (c <= "9");
    assign c_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign c_wordch = c_digit || c_alpha || (c == "_");
    assign len_up  = (r_len < 8'(LEN_CAP)) ? r_len + 8'd1 : r_len;

    // Keyword table: parallel compare on the buffered word.
    always_comb begin
        kw = K_WORD;
        if (r_len == 8'd2 && r_buf[0] == "i" && r_buf[1] == "f") begin
            kw = K_IF;
        end else if (r_len == 8'd3 && r_buf[0] == "f" && r_buf[1] == "o" && r_buf[2] == "r") begin
            kw = K_FOR;
        end else if (r_len == 8'd5 && r_buf[0] == "w" && r_buf[1] == "h" && r_buf[2] == "i"
                     && r_buf[3] == "l" && r_buf[4] == "e") begin
            kw = K_WHILE;
        end else if (r_len == 8'd4 && r_buf[0] == "e" && r_buf[1] == "l" && r_buf[2] == "s"
                     && r_buf[3] == "e") begin
            kw = K_ELSE;
        end else if (r_len == 8'd3 && r_buf[0] == "N" && r_buf[1] == "a" && r_buf[2] == "N") begin
            kw = K_NAN;
        end else if (r_len == 8'd8 && r_buf[0] == "f" && r_buf[1] == "u" && r_buf[2] == "n"
                     && r_buf[3] == "c" && r_buf[4] == "t" && r_buf[5] == "i"
                     && r_buf[6] == "o" && r_buf[7] == "n") begin
            kw = K_FUNCTION;
        end else if (r_len == 8'd9 && r_buf[0] == "u" && r_buf[1] == "n" && r_buf[2] == "d"
                     && r_buf[3] == "e" && r_buf[4] == "f" && r_buf[5] == "i"
                     && r_buf[6] == "n" && r_buf[7] == "e" && r_buf[8] == "d") begin
            kw = K_UNDEFINED;
        end else if (r_len == 8'd4 && r_buf[0] == "n" && r_buf[1] == "u" && r_buf[2] == "l"
                     && r_buf[3] == "l") begin
            kw = K_NULL;
        end else if (r_len == 8'd4 && r_buf[0] == "t" && r_buf[1] == "h" && r_buf[2] == "i"
                     && r_buf[3] == "s") begin
            kw = K_THIS;
        end else if (r_len == 8'd3 && r_buf[0] == "n" && r_buf[1] == "e" && r_buf[2] == "w") begin
            kw = K_NEW;
        end else if (r_len == 8'd6 && r_buf[0] == "r" && r_buf[1] == "e" && r_buf[2] == "t"
                     && r_buf[3] == "u" && r_buf[4] == "r" && r_buf[5] == "n") begin
            kw = K_RETURN;
        end else if (r_len == 8'd6 && r_buf[0] == "t" && r_buf[1] == "y" && r_buf[2] == "p"
                     && r_buf[3] == "e" && r_buf[4] == "o" && r_buf[5] == "f") begin
            kw = K_TYPEOF;
        end else if ((r_len == 8'd4 && r_buf[0] == "t" && r_buf[1] == "r" && r_buf[2] == "u"
                      && r_buf[3] == "e")
                  || (r_len == 8'd5 && r_buf[0] == "f" && r_buf[1] == "a" && r_buf[2] == "l"
                      && r_buf[3] == "s" && r_buf[4] == "e")) begin
            kw = K_BOOLEAN;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_len   = r_len;
        n_start = r_start;
        n_pos   = r_pos;
        n_quote = r_quote;
        n_point = r_point;
        n_eq    = r_eq;
        buf_we  = 1'b0;
        buf_idx = r_len[KW_W-1:0];
        tok[0]  = '0;
        tok[1]  = '0;
        ntok    = 2'd0;
        redo    = 1'b0;
        if (i_accept) begin
            if (i_end) begin
                unique case (r_mode)
                    M_PLUS:    begin tok[0] = '{K_PLUS, 8'd0, r_start, E_NONE}; ntok = 2'd1; end
                    M_MINUS:   begin tok[0] = '{K_MINUS, 8'd0, r_start, E_NONE}; ntok = 2'd1; end
                    M_BANG:    begin tok[0] = '{K_INVERSE, 8'd0, r_start, E_NONE}; ntok = 2'd1; end
                    M_BANG_EQ: begin tok[0] = '{K_NOT_EQ, 8'd0, r_start, E_NONE}; ntok = 2'd1; end
                    M_SLASH:   begin tok[0] = '{K_DIV, 8'd1, r_start, E_NONE}; ntok = 2'd1; end
                    M_LINE: begin
                        tok[0] = '{K_LINE_COMMENT, r_len, r_start, E_NONE};
                        ntok = 2'd1;
                    end
                    M_BLOCK, M_BLOCK_STAR: begin
                        tok[0] = '{K_BLOCK_COMMENT, r_len, r_start, E_NONE};
                        ntok = 2'd1;
                    end
                    M_EQ: begin
                        if (r_eq == 3'd1) begin
                            tok[0] = '{K_ASSIGN, 8'd1, r_start, E_NONE}; ntok = 2'd1;
                        end else if (r_eq == 3'd2) begin
                            tok[0] = '{K_EQ, 8'd2, r_start, E_NONE}; ntok = 2'd1;
                        end else if (r_eq == 3'd3) begin
                            tok[0] = '{K_EQ_STRICT, 8'd3, r_start, E_NONE}; ntok = 2'd1;
                        end
                    end
                    M_LT:  begin tok[0] = '{K_LT, 8'd1, r_start, E_NONE}; ntok = 2'd1; end
                    M_GT:  begin tok[0] = '{K_GT, 8'd1, r_start, E_NONE}; ntok = 2'd1; end
                    M_AMP: begin tok[0] = '{K_AND, 8'd1, r_start, E_NONE}; ntok = 2'd1; end
                    M_BAR: begin tok[0] = '{K_OR, 8'd1, r_start, E_NONE}; ntok = 2'd1; end
                    M_STR: begin tok[0] = '{K_STRING, r_len, r_start, E_UNTERM}; ntok = 2'd1; end
                    M_NUM: begin tok[0] = '{K_NUMBER, r_len, r_start, E_NONE}; ntok = 2'd1; end
                    M_WORD: begin
                        tok[0] = '{kw, r_len, r_start,
                                   (kw == K_IF || kw == K_FOR || kw == K_WHILE)
                                   ? E_NO_PAREN : E_NONE};
                        ntok = 2'd1;
                    end
                    M_WAIT_IF:    begin tok[0] = '{K_IF, r_len, r_start, E_NO_PAREN}; ntok = 2'd1; end
                    M_WAIT_FOR:   begin tok[0] = '{K_FOR, r_len, r_start, E_NO_PAREN}; ntok = 2'd1; end
                    M_WAIT_WHILE: begin tok[0] = '{K_WHILE, r_len, r_start, E_NO_PAREN}; ntok = 2'd1; end
                    default: ;
                endcase
                n_mode  = M_IDLE;
                n_pos   = '0;
                n_start = '0;
                n_len   = '0;
                n_point = 1'b0;
                n_eq    = '0;
            end else begin
                unique case (r_mode)
                    M_IDLE: redo = 1'b1;
                    M_PLUS, M_MINUS: begin
                        if (c == " ") begin
                        end else if (c == ((r_mode == M_PLUS) ? "+" : "-")) begin
                            tok[0] = '{(r_mode == M_PLUS) ? K_INCREMENT : K_DECREMENT,
                                       8'd0, r_start, E_NONE};
                            ntok = 2'd1;
                            n_mode = M_IDLE;
                        end else begin
                            tok[0] = '{(r_mode == M_PLUS) ? K_PLUS : K_MINUS,
                                       8'd0, r_start, E_NONE};
                            ntok = 2'd1;
                            redo = 1'b1;
                        end
                    end
                    M_BANG: begin
                        if (c == "=") begin
                            n_mode = M_BANG_EQ;
                        end else begin
                            tok[0] = '{K_INVERSE, 8'd0, r_start, E_NONE}; ntok = 2'd1;
                            redo = 1'b1;
                        end
                    end
                    M_BANG_EQ: begin
                        if (c == "=") begin
                            tok[0] = '{K_NOT_EQ_STRICT, 8'd0, r_start, E_NONE}; ntok = 2'd1;
                            n_mode = M_IDLE;
                        end else begin
                            tok[0] = '{K_NOT_EQ, 8'd0, r_start, E_NONE}; ntok = 2'd1;
                            redo = 1'b1;
                        end
                    end
                    M_SLASH: begin
                        if (c == "/") begin
                            n_mode = M_LINE; n_len = 8'd2;
                        end else if (c == "*") begin
                            n_mode = M_BLOCK; n_len = 8'd2;
                        end else begin
                            tok[0] = '{K_DIV, 8'd1, r_start, E_NONE}; ntok = 2'd1;
                            redo = 1'b1;
                        end
                    end
                    M_LINE: begin
                        if (c == 8'h0a) begin
                            tok[0] = '{K_LINE_COMMENT, r_len, r_start, E_NONE}; ntok = 2'd1;
                            redo = 1'b1;
                        end else begin
                            n_len = len_up;
                        end
                    end
                    M_BLOCK: begin
                        n_len = len_up;
                        if (c == "*") n_mode = M_BLOCK_STAR;
                    end
                    M_BLOCK_STAR: begin
                        if (c == "/") begin
                            tok[0] = '{K_BLOCK_COMMENT, r_len, r_start, E_NONE}; ntok = 2'd1;
                            n_mode = M_IDLE;
                        end else begin
                            n_len = len_up;
                            if (c != "*") n_mode = M_BLOCK;
                        end
                    end
                    M_EQ: begin
                        if (c == "=") begin
                            if (r_eq < 3'd4) n_eq = r_eq + 3'd1;
                        end else begin
                            if (r_eq == 3'd1) begin
                                tok[0] = '{K_ASSIGN, 8'd1, r_start, E_NONE}; ntok = 2'd1;
                            end else if (r_eq == 3'd2) begin
                                tok[0] = '{K_EQ, 8'd2, r_start, E_NONE}; ntok = 2'd1;
                            end else if (r_eq == 3'd3) begin
                                tok[0] = '{K_EQ_STRICT, 8'd3, r_start, E_NONE}; ntok = 2'd1;
                            end
                            redo = 1'b1;
                        end
                    end
                    M_LT, M_GT: begin
                        if (c == "=") begin
                            tok[0] = '{(r_mode == M_LT) ? K_LE : K_GE, 8'd2, r_start, E_NONE};
                            ntok = 2'd1;
                            n_mode = M_IDLE;
                        end else begin
                            tok[0] = '{(r_mode == M_LT) ? K_LT : K_GT, 8'd1, r_start, E_NONE};
                            ntok = 2'd1;
                            redo = 1'b1;
                        end
                    end
                    M_AMP, M_BAR: begin
                        if (c == ((r_mode == M_AMP) ? "&" : "|")) begin
                            tok[0] = '{(r_mode == M_AMP) ? K_AND : K_OR, 8'd2, r_start, E_NONE};
                            ntok = 2'd1;
                            n_mode = M_IDLE;
                        end else begin
                            tok[0] = '{(r_mode == M_AMP) ? K_AND : K_OR, 8'd1, r_start, E_NONE};
                            ntok = 2'd1;
                            redo = 1'b1;
                        end
                    end
                    M_STR: begin
                        if (c == r_quote || c == 8'h0a) begin
                            tok[0] = '{K_STRING, r_len, r_start,
                                       (c == 8'h0a) ? E_UNTERM : E_NONE};
                            ntok = 2'd1;
                            n_mode = M_IDLE;
                        end else begin
                            n_len = len_up;
                        end
                    end
                    M_NUM: begin
                        if (c_digit) begin
                            n_len = len_up;
                        end else if (c == ".") begin
                            if (r_point) begin
                                tok[0] = '{K_NUMBER, r_len, r_start, E_TWO_POINT};
                                ntok = 2'd1;
                                n_mode = M_IDLE;
                            end else begin
                                n_point = 1'b1;
                                n_len = len_up;
                            end
                        end else begin
                            tok[0] = '{K_NUMBER, r_len, r_start, E_NONE}; ntok = 2'd1;
                            redo = 1'b1;
                        end
                    end
                    M_WORD: begin
                        if (c_wordch) begin
                            buf_we = (r_len < 8'(KEYWORD_CHARS));
                            n_len = len_up;
                        end else if (kw == K_IF || kw == K_FOR || kw == K_WHILE) begin
                            // Word ends: a keyword that needs '(' waits through spaces.
                            if (c == " ") begin
                                n_mode = (kw == K_IF) ? M_WAIT_IF
                                       : (kw == K_FOR) ? M_WAIT_FOR : M_WAIT_WHILE;
                            end else begin
                                tok[0] = '{kw, r_len, r_start,
                                           (c == "(") ? E_NONE : E_NO_PAREN};
                                ntok = 2'd1;
                                redo = 1'b1;
                            end
                        end else begin
                            tok[0] = '{kw, r_len, r_start, E_NONE}; ntok = 2'd1;
                            n_mode = M_IDLE;
                            redo = !(kw == K_ELSE || kw == K_RETURN || kw == K_TYPEOF);
                        end
                    end
                    M_WAIT_IF, M_WAIT_FOR, M_WAIT_WHILE: begin
                        if (c != " ") begin
                            tok[0] = '{(r_mode == M_WAIT_IF) ? K_IF
                                       : (r_mode == M_WAIT_FOR) ? K_FOR : K_WHILE,
                                       r_len, r_start, (c == "(") ? E_NONE : E_NO_PAREN};
                            ntok = 2'd1;
                            redo = 1'b1;
                        end
                    end
                    default: redo = 1'b1;
                endcase

                // Byte starts a new token from idle.
                if (redo) begin
                    n_mode  = M_IDLE;
                    n_start = r_pos;
                    n_len   = '0;
                    case (c)
                        "+": n_mode = M_PLUS;
                        "-": n_mode = M_MINUS;
                        "!": n_mode = M_BANG;
                        "/": n_mode = M_SLASH;
                        "=": begin n_mode = M_EQ; n_eq = 3'd1; end
                        "<": n_mode = M_LT;
                        ">": n_mode = M_GT;
                        "&": n_mode = M_AMP;
                        "|": n_mode = M_BAR;
                        "'", "\"": begin n_mode = M_STR; n_quote = c; end
                        "*", ",", "(", ")", ";", "{", ":", "[", "]", "}", ".": begin
                            tok[ntok[0]].start = r_pos;
                            tok[ntok[0]].len   = 8'd0;
                            tok[ntok[0]].err   = E_NONE;
                            case (c)
                                "*": tok[ntok[0]].kind = K_STAR;
                                ",": tok[ntok[0]].kind = K_COMMA;
                                "(": tok[ntok[0]].kind = K_LPAREN;
                                ")": tok[ntok[0]].kind = K_RPAREN;
                                ";": tok[ntok[0]].kind = K_SEMI;
                                "{": tok[ntok[0]].kind = K_LBRACE;
                                ":": tok[ntok[0]].kind = K_COLON;
                                "[": tok[ntok[0]].kind = K_LSQ;
                                "]": tok[ntok[0]].kind = K_RSQ;
                                "}": tok[ntok[0]].kind = K_RBRACE;
                                default: tok[ntok[0]].kind = K_DOT;
                            endcase
                            ntok = ntok + 2'd1;
                        end
                        default: begin
                            if (c_digit) begin
                                n_mode = M_NUM; n_point = 1'b0; n_len = 8'd1;
                            end else if (c_alpha || c == "_") begin
                                n_mode = M_WORD; n_len = 8'd1;
                                buf_we = 1'b1; buf_idx = '0;
                            end
                        end
                    endcase
                end
                n_pos = r_pos + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_len   <= '0;
            r_start <= '0;
            r_pos   <= '0;
            r_quote <= '0;
            r_point <= 1'b0;
            r_eq    <= '0;
        end else begin
            r_mode  <= n_mode;
            r_len   <= n_len;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_quote <= n_quote;
            r_point <= n_point;
            r_eq    <= n_eq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) r_buf[buf_idx] <= c;
    end

    assign o_push.push      = (ntok != 2'd0);
    assign o_push.data.two  = ntok[1];
    assign o_push.data.tok0 = tok[0];
    assign o_push.data.tok1 = tok[1];

endmodule

// ----- rtl/stl_queue.sv -----
// Two-entry queue of token bundles between scanner and output stage.
`timescale 1ns / 1ps
module stl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stl_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output stl_pkg::t_bundle o_head
);
    import stl_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    t_bundle       r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [PW:0]   r_cnt, n_cnt;
    logic          push, pop;

    assign push    = i_push.push;
    assign pop     = i_pop && !o_empty;
    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp  = push ? r_wp + PW'(1) : r_wp;
        n_rp  = pop ? r_rp + PW'(1) : r_rp;
        n_cnt = r_cnt + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_push.data;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> !o_full) else $error("bundle pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

// ----- rtl/stl_back.sv -----
// Back end: splits each bundle into single token transactions.
`timescale 1ns / 1ps
module stl_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  stl_pkg::t_bundle i_head,
    output logic             o_pop,
    stl_out_if.source        o_out
);
    import stl_pkg::*;

    logic   r_sel, n_sel;
    logic   last;
    t_token cur;

    assign cur  = r_sel ? i_head.tok1 : i_head.tok0;
    assign last = r_sel || !i_head.two;

    assign o_out.valid        = !i_empty;
    assign o_out.token_kind   = cur.kind;
    assign o_out.text_length  = cur.len;
    assign o_out.start_offset = cur.start;
    assign o_out.error_code   = cur.err;
    assign o_out.last_of_run  = last;

    assign o_pop = o_out.valid && o_out.ready && last;

    always_comb begin
        n_sel = r_sel;
        if (o_out.valid && o_out.ready) n_sel = !last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else begin
            r_sel <= n_sel;
        end
    end

endmodule

// ----- rtl/script_token_lexer.sv -----
// Top level: script tokenizer, byte stream in, token stream out.
//
// Usage:
//   i_in  carries one source byte per transaction (char_code) with an
//         end_of_text flag; an end-of-text transaction flushes any pending
//         token, ignores its byte and restarts the byte offset at zero.
//   o_out carries one token per transaction: kind, text length
//         (saturating), start offset, error code and last_of_run, set on
//         the final token caused by one input transaction.
// Throughput: one byte per cycle while the queue has room; a byte that
//   completes two tokens leaves as two o_out transactions (one port).
// Output: a completed token is written into the bundle queue and is
//   presented on o_out from the queue head, behind any earlier bundles.
// Stall: a two-entry bundle queue sits between scanner and output; when
//   the receiver holds ready low the queue fills and i_in.ready drops
//   after two pending bundles. The scanner never stalls mid-byte.
// Reset: synchronous, active low; scanner returns to idle with offset
//   zero and the queue empties. No clearing pass is needed.
`timescale 1ns / 1ps
module script_token_lexer #(
    parameter int unsigned MAX_TEXT_LEN  = stl_pkg::MAX_TEXT_LEN_DEF,
    parameter int unsigned KEYWORD_CHARS = stl_pkg::KEYWORD_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stl_in_if.sink     i_in,
    stl_out_if.source  o_out
);
    import stl_pkg::*;

    t_push   push;
    t_bundle head;
    logic    full, empty, pop, accept;

    // Ready depends only on queue room, not on the output side.
    assign i_in.ready = !full;
    assign accept     = i_in.valid && !full;

    stl_front #(
        .MAX_TEXT_LEN  (MAX_TEXT_LEN),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_in.char_code),
        .i_end    (i_in.end_of_text),
        .o_push   (push)
    );

    stl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    stl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
